// File: rtl/dsq_pkg.sv
// ----------------------------------------------------------------------------
// dsq_pkg
// Shared types and constants for the deadline service queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dsq_pkg;

    localparam int FUNC_W  = 2;
    localparam int TIME_FW = 13;
    localparam int INDEX_FW = 10;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR = 2'd0,
        FN_ADD   = 2'd1,
        FN_TICK  = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_READ = 2'd2,
        ST_DONE = 2'd3
    } t_state;

endpackage

`default_nettype wire

// File: rtl/dsq_ram.sv
// ----------------------------------------------------------------------------
// dsq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/deadline_service_queue_top.sv
// ----------------------------------------------------------------------------
// deadline_service_queue_top
// Request table with arrival and deadline times, at most one served per tick.
// ----------------------------------------------------------------------------
// Clear and add pass from IDLE to DONE, then into the result register.
// Read passes through READ for the RAM data. Tick scans the table one entry per
// cycle through the single table RAM read port, stopping at the first eligible entry.
// One request in flight at a time; a new request is taken while a result waits.
// Synchronous active-low reset: empty table, time at 1, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_service_queue_top #(
    parameter int ENTRIES    = 1024,
    parameter int TIME_LIMIT = 8191
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [dsq_pkg::FUNC_W-1:0]      i_func,
    input  wire logic [dsq_pkg::TIME_FW-1:0]     i_arrival_time,
    input  wire logic [dsq_pkg::TIME_FW-1:0]     i_deadline_time,
    input  wire logic [dsq_pkg::INDEX_FW-1:0]    i_entry_index,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_hit,
    output logic      [dsq_pkg::INDEX_FW-1:0]    o_result_index,
    output logic      [dsq_pkg::TIME_FW-1:0]     o_service_time,
    output logic                                 o_table_full
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int TW = $clog2(TIME_LIMIT + 1);
    localparam int WW = (CW > dsq_pkg::INDEX_FW) ? CW : dsq_pkg::INDEX_FW;
    localparam int SW = (TW > dsq_pkg::TIME_FW) ? TW : dsq_pkg::TIME_FW;
    localparam int DW = 2 * dsq_pkg::TIME_FW + TW;

    dsq_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [TW-1:0]   r_time, n_time;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_res_hit, n_res_hit;
    logic [dsq_pkg::INDEX_FW-1:0] r_res_index, n_res_index;
    logic [dsq_pkg::TIME_FW-1:0]  r_res_service, n_res_service;
    logic            r_res_full, n_res_full;

    logic            w_we;
    logic [IW-1:0]   w_waddr, w_raddr;
    logic [DW-1:0]   w_wdata, w_rdata;

    logic [dsq_pkg::TIME_FW-1:0] w_arr, w_dl;
    logic [TW-1:0]   w_srv;
    logic [SW-1:0]   w_time_ext, w_srv_ext;
    logic [WW-1:0]   w_req_ext, w_idx_ext, w_cnt_ext;
    logic [CW:0]     w_idx_next;
    logic [TW-1:0]   w_time_adv;
    logic            w_accept, w_eligible, w_load;

    assign w_arr      = w_rdata[DW-1 -: dsq_pkg::TIME_FW];
    assign w_dl       = w_rdata[TW +: dsq_pkg::TIME_FW];
    assign w_srv      = w_rdata[TW-1:0];
    assign w_time_ext = SW'(r_time);
    assign w_srv_ext  = SW'(w_srv);
    assign w_req_ext  = WW'(i_entry_index);
    assign w_idx_ext  = WW'(r_idx);
    assign w_cnt_ext  = WW'(r_count);
    assign w_idx_next = (CW + 1)'(r_idx) + (CW + 1)'(1);
    assign w_time_adv = (r_time < TW'(TIME_LIMIT)) ? r_time + TW'(1) : r_time;
    assign w_eligible = (w_srv == '0) && (SW'(w_arr) <= w_time_ext)
                        && (SW'(w_dl) >= w_time_ext);

    assign o_in_ready = (r_state == dsq_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = (r_state == dsq_pkg::ST_DONE) && (!o_out_valid || i_out_ready);

    dsq_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_time        = r_time;
        n_idx         = r_idx;
        n_res_hit     = r_res_hit;
        n_res_index   = r_res_index;
        n_res_service = r_res_service;
        n_res_full    = r_res_full;
        w_we          = 1'b0;
        w_waddr       = r_count[IW-1:0];
        w_wdata       = {i_arrival_time, i_deadline_time, TW'(0)};
        w_raddr       = w_idx_next[IW-1:0];
        case (r_state)
            dsq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_res_hit     = 1'b0;
                    n_res_index   = '0;
                    n_res_service = '0;
                    n_res_full    = 1'b0;
                    n_state       = dsq_pkg::ST_DONE;
                    case (dsq_pkg::t_func'(i_func))
                        dsq_pkg::FN_CLEAR: begin
                            n_count = '0;
                            n_time  = TW'(1);
                        end
                        dsq_pkg::FN_ADD: begin
                            if (r_count < CW'(ENTRIES)) begin
                                w_we        = 1'b1;
                                n_res_hit   = 1'b1;
                                n_res_index = w_cnt_ext[dsq_pkg::INDEX_FW-1:0];
                                n_count     = r_count + CW'(1);
                            end else begin
                                n_res_full = 1'b1;
                            end
                        end
                        dsq_pkg::FN_TICK: begin
                            w_raddr = '0;
                            n_idx   = '0;
                            if (r_count == '0) begin
                                n_time = w_time_adv;
                            end else begin
                                n_state = dsq_pkg::ST_SCAN;
                            end
                        end
                        dsq_pkg::FN_READ: begin
                            w_raddr     = w_req_ext[IW-1:0];
                            n_res_index = i_entry_index;
                            n_res_hit   = (w_req_ext < w_cnt_ext);
                            n_state     = dsq_pkg::ST_READ;
                        end
                        default: begin
                            n_state = dsq_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            dsq_pkg::ST_SCAN: begin
                if (w_eligible) begin
                    w_we          = 1'b1;
                    w_waddr       = r_idx;
                    w_wdata       = {w_arr, w_dl, r_time};
                    n_res_hit     = 1'b1;
                    n_res_index   = w_idx_ext[dsq_pkg::INDEX_FW-1:0];
                    n_res_service = w_time_ext[dsq_pkg::TIME_FW-1:0];
                    n_time        = w_time_adv;
                    n_state       = dsq_pkg::ST_DONE;
                end else if (w_idx_next == (CW + 1)'(r_count)) begin
                    n_time  = w_time_adv;
                    n_state = dsq_pkg::ST_DONE;
                end else begin
                    n_idx = w_idx_next[IW-1:0];
                end
            end
            dsq_pkg::ST_READ: begin
                n_res_service = r_res_hit ? w_srv_ext[dsq_pkg::TIME_FW-1:0] : '0;
                n_state       = dsq_pkg::ST_DONE;
            end
            dsq_pkg::ST_DONE: begin
                if (w_load) begin
                    n_state = dsq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dsq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsq_pkg::ST_IDLE;
            r_count     <= '0;
            r_time      <= TW'(1);
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_time  <= n_time;
            if (w_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_res_hit     <= n_res_hit;
        r_res_index   <= n_res_index;
        r_res_service <= n_res_service;
        r_res_full    <= n_res_full;
        if (w_load) begin
            o_hit          <= r_res_hit;
            o_result_index <= r_res_index;
            o_service_time <= r_res_service;
            o_table_full   <= r_res_full;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dsq_checker.sv
// ----------------------------------------------------------------------------
// dsq_checker
// Port-level checks for the deadline service queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dsq_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic                         o_hit,
    input wire logic [dsq_pkg::INDEX_FW-1:0] o_result_index,
    input wire logic [dsq_pkg::TIME_FW-1:0]  o_service_time,
    input wire logic                         o_table_full
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit)
            && $stable(o_result_index) && $stable(o_service_time)
            && $stable(o_table_full))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one in flight");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_full |-> !o_hit && o_result_index == '0
            && o_service_time == '0)
        else $error("refused add carries data");

endmodule

bind deadline_service_queue_top dsq_checker u_dsq_checker (.*);

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the deadline service queue. A clocked driver offers requests
// from a queue built up front, and a clocked monitor compares every result
// with an in-bench model of the table, the clock and the service marks.
// Directed cases come first, then random clear/add/tick/read sequences mixed
// with noise. Both sides idle at random; the receiver also holds off for
// long stretches so that the block backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int ENTRIES    = 1024;
    localparam int TIME_LIMIT = 8191;
    localparam int CYCLE_CAP  = 2000000;
    localparam int STALL_LEN  = 300;
    localparam int RANDOM_ITEMS = 520;

    typedef struct packed {
        dsq_pkg::t_func                func;
        logic [dsq_pkg::TIME_FW-1:0]   arrival;
        logic [dsq_pkg::TIME_FW-1:0]   deadline;
        logic [dsq_pkg::INDEX_FW-1:0]  index;
    } t_request;

    typedef struct packed {
        logic                          hit;
        logic [dsq_pkg::INDEX_FW-1:0]  idx;
        logic [dsq_pkg::TIME_FW-1:0]   stime;
        logic                          full;
    } t_outcome;

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    t_request cur_req = '0;

    logic                         in_ready;
    logic                         out_valid;
    logic                         hit;
    logic [dsq_pkg::INDEX_FW-1:0] result_index;
    logic [dsq_pkg::TIME_FW-1:0]  service_time;
    logic                         table_full;

    t_request requests_todo[$];
    t_outcome outcomes_due[$];

    logic [dsq_pkg::TIME_FW-1:0] arrive_tab[ENTRIES];
    logic [dsq_pkg::TIME_FW-1:0] due_tab[ENTRIES];
    logic [dsq_pkg::TIME_FW-1:0] stamp_tab[ENTRIES];
    int                          held_count = 0;
    logic [dsq_pkg::TIME_FW-1:0] clock_now = 1;

    int       cycle = 0;
    int       errors = 0;
    int       stall_left = 0;
    int       stall_mark = 600;
    t_outcome want;

    deadline_service_queue_top #(
        .ENTRIES    (ENTRIES),
        .TIME_LIMIT (TIME_LIMIT)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_func          (cur_req.func),
        .i_arrival_time  (cur_req.arrival),
        .i_deadline_time (cur_req.deadline),
        .i_entry_index   (cur_req.index),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_hit           (hit),
        .o_result_index  (result_index),
        .o_service_time  (service_time),
        .o_table_full    (table_full)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic bit take_break();
        return (cycle % 25000 >= 4000) && ($urandom_range(0, 99) < 31);
    endfunction

    function automatic t_outcome service_outcome(t_request r);
        t_outcome o;
        int k;
        o = '0;
        case (r.func)
            dsq_pkg::FN_CLEAR: begin
                for (k = 0; k < ENTRIES; k++) stamp_tab[k] = '0;
                held_count = 0;
                clock_now = 1;
            end
            dsq_pkg::FN_ADD: begin
                if (held_count < ENTRIES) begin
                    arrive_tab[held_count] = r.arrival;
                    due_tab[held_count]    = r.deadline;
                    stamp_tab[held_count]  = '0;
                    o.hit = 1'b1;
                    o.idx = dsq_pkg::INDEX_FW'(held_count);
                    held_count++;
                end else begin
                    o.full = 1'b1;
                end
            end
            dsq_pkg::FN_TICK: begin
                for (k = 0; k < held_count && !o.hit; k++) begin
                    if (stamp_tab[k] == 0 && arrive_tab[k] <= clock_now &&
                        due_tab[k] >= clock_now) begin
                        stamp_tab[k] = clock_now;
                        o.hit   = 1'b1;
                        o.idx   = dsq_pkg::INDEX_FW'(k);
                        o.stime = clock_now;
                    end
                end
                if (clock_now < TIME_LIMIT) clock_now++;
            end
            default: begin
                o.idx = r.index;
                if (r.index < held_count) begin
                    o.hit   = 1'b1;
                    o.stime = stamp_tab[r.index];
                end
            end
        endcase
        return o;
    endfunction

    task automatic queue_request(dsq_pkg::t_func f, int a, int d, int ix);
        t_request r;
        r.func     = f;
        r.arrival  = dsq_pkg::TIME_FW'(a);
        r.deadline = dsq_pkg::TIME_FW'(d);
        r.index    = dsq_pkg::INDEX_FW'(ix);
        requests_todo.insert(requests_todo.size(), r);
    endtask

    function automatic int any_time();
        return $urandom_range(1, TIME_LIMIT);
    endfunction

    function automatic int any_index();
        return $urandom_range(0, ENTRIES - 1);
    endfunction

    task automatic queue_sequence();
        int n_add, n_ops, k, a, sel;
        queue_request(dsq_pkg::FN_CLEAR, any_time(), any_time(), any_index());
        n_add = $urandom_range(1, 40);
        for (k = 0; k < n_add; k++) begin
            a = $urandom_range(1, 30);
            queue_request(dsq_pkg::FN_ADD, a, (a + $urandom_range(0, 20) > TIME_LIMIT) ?
                          TIME_LIMIT : a + $urandom_range(0, 20), any_index());
        end
        n_ops = $urandom_range(5, 40);
        for (k = 0; k < n_ops; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                queue_request(dsq_pkg::FN_TICK, any_time(), any_time(), any_index());
            end else if (sel < 85) begin
                queue_request(dsq_pkg::FN_READ, any_time(), any_time(),
                              ($urandom_range(0, 3) == 0) ? any_index()
                                                         : $urandom_range(0, n_add + 2));
            end else begin
                a = $urandom_range(1, 60);
                queue_request(dsq_pkg::FN_ADD, a, a + $urandom_range(0, 30), any_index());
            end
        end
    endtask

    task automatic queue_noise();
        int n, k;
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
            queue_request(dsq_pkg::t_func'($urandom_range(0, 3)), any_time(), any_time(),
                          any_index());
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                outcomes_due.insert(outcomes_due.size(), service_outcome(cur_req));
            if (!in_valid || in_ready) begin
                if (requests_todo.size() != 0 && !take_break()) begin
                    cur_req  <= requests_todo.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (outcomes_due.size() == 0) begin
                $error("result with nothing outstanding: index %0d", result_index);
                errors++;
            end else begin
                want = outcomes_due.pop_front();
                if (hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, hit);
                    errors++;
                end
                if (result_index !== want.idx) begin
                    $error("result_index: expected %0d, got %0d", want.idx, result_index);
                    errors++;
                end
                if (service_time !== want.stime) begin
                    $error("service_time: expected %0d, got %0d", want.stime, service_time);
                    errors++;
                end
                if (table_full !== want.full) begin
                    $error("table_full: expected %0d, got %0d", want.full, table_full);
                    errors++;
                end
            end
        end
    end

    // receiver: random idling plus long hold-offs counted in cycles
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (cycle >= stall_mark) begin
            stall_left = STALL_LEN;
            stall_mark += 2500;
            out_ready <= 1'b0;
        end else begin
            out_ready <= !take_break();
        end
    end

    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int k, base;

        // directed: empty table, deadline and arrival bounds, served order
        queue_request(dsq_pkg::FN_READ, 1, 1, 0);
        queue_request(dsq_pkg::FN_TICK, 1, 1, 0);
        queue_request(dsq_pkg::FN_CLEAR, TIME_LIMIT, TIME_LIMIT, ENTRIES - 1);
        queue_request(dsq_pkg::FN_ADD, 1, 1, 0);
        queue_request(dsq_pkg::FN_ADD, TIME_LIMIT, TIME_LIMIT, ENTRIES - 1);
        queue_request(dsq_pkg::FN_ADD, 1, TIME_LIMIT, 0);
        queue_request(dsq_pkg::FN_ADD, 2, 3, 0);
        for (k = 0; k < 4; k++) queue_request(dsq_pkg::FN_TICK, 1, 1, 0);
        for (k = 0; k < 5; k++) queue_request(dsq_pkg::FN_READ, 1, 1, k);
        queue_request(dsq_pkg::FN_READ, 1, 1, ENTRIES - 1);
        queue_request(dsq_pkg::FN_ADD, 4, 4, 0);
        queue_request(dsq_pkg::FN_ADD, 5, 5, 0);
        queue_request(dsq_pkg::FN_TICK, TIME_LIMIT, TIME_LIMIT, ENTRIES - 1);
        queue_request(dsq_pkg::FN_READ, 1, 1, 4);
        queue_request(dsq_pkg::FN_READ, 1, 1, 5);
        queue_request(dsq_pkg::FN_CLEAR, 1, 1, 0);
        queue_request(dsq_pkg::FN_READ, 1, 1, 0);
        queue_request(dsq_pkg::FN_TICK, 1, 1, 0);

        base = requests_todo.size();
        while (requests_todo.size() - base < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            else queue_sequence();
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_todo.size() != 0 || in_valid) @(posedge clk);
        while (outcomes_due.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
